FILE: hdl/grerode_pkg.sv
// Shared types, constants and helper functions for the 3x3 grayscale erosion block.
`timescale 1ns / 1ps
package grerode_pkg;

   // Sizes and configuration defaults
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int PIX_W             = 8;
   localparam int WIDTH_REG_W       = 11;
   localparam int HEIGHT_REG_W      = 13;
   localparam int ROW_W             = 12;
   localparam int MAX_HEIGHT        = 4096;
   localparam int MIN_SIZE          = 3;
   localparam int WIDTH_RESET       = 640;
   localparam int HEIGHT_RESET      = 480;
   localparam int CSR_DATA_W        = 13;
   localparam int CSR_INDEX_W       = 1;

   // Queue depths (powers of two)
   localparam int CMD_DEPTH = 4;
   localparam int RES_DEPTH = 4;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Input transfer
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_payload_type;

   // Output transfer
   typedef struct packed {
      logic [PIX_W-1:0] eroded_pixel;
      logic             row_end;
      logic             frame_end;
   } rsp_payload_type;

   // Classification of one pixel, front to back
   typedef struct packed {
      logic emit;
      logic row_end;
      logic frame_end;
   } cmd_flags_type;

   function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
      logic [PIX_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

endpackage

FILE: hdl/grerode_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module grerode_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Read returns the contents before a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/grerode_fifo.sv
// Small register-based FIFO with valid/ready on both sides and a fill level.
`timescale 1ns / 1ps
module grerode_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != LW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign level      = count_ff;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + LW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/grerode_front.sv
// Front end: configuration registers, raster position tracking and pixel classification.
`timescale 1ns / 1ps
module grerode_front
   import grerode_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  req_payload_type              req_payload,
   input  logic                         csr_write,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output logic [$clog2(MAX_WIDTH)-1:0] cmd_index,
   output logic [PIX_W-1:0]             cmd_pixel,
   output cmd_flags_type                cmd_flags
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WCMP = (WIDTH_REG_W > CW + 1) ? WIDTH_REG_W : CW + 1;
   localparam int HCMP = HEIGHT_REG_W;

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [CW-1:0]           col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [WCMP-1:0]         width_eff, width_ext, col_next;
   logic [HCMP-1:0]         height_eff, row_next;
   logic [CW-1:0]           col_cur;
   logic [ROW_W-1:0]        row_cur;
   logic                    last_col, last_row, accept;

   // Configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the frame size to the supported range
   always_comb begin
      width_ext = WCMP'(width_ff);
      if (width_ext < WCMP'(MIN_SIZE)) begin
         width_eff = WCMP'(MIN_SIZE);
      end else if (width_ext > WCMP'(MAX_WIDTH)) begin
         width_eff = WCMP'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      if (height_ff < HCMP'(MIN_SIZE)) begin
         height_eff = HCMP'(MIN_SIZE);
      end else if (height_ff > HCMP'(MAX_HEIGHT)) begin
         height_eff = HCMP'(MAX_HEIGHT);
      end else begin
         height_eff = height_ff;
      end
   end

   // Position of this pixel and its classification
   always_comb begin
      col_cur   = req_payload.frame_start ? '0 : col_ff;
      row_cur   = req_payload.frame_start ? '0 : row_ff;
      col_next  = WCMP'(col_cur) + WCMP'(1);
      row_next  = HCMP'(row_cur) + HCMP'(1);
      last_col  = (col_next >= width_eff);
      last_row  = (row_next >= height_eff);

      cmd_flags.emit      = (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));
      cmd_flags.row_end   = last_col;
      cmd_flags.frame_end = last_col && last_row;
   end

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign cmd_index = col_cur;
   assign cmd_pixel = req_payload.pixel;
   assign accept    = req_valid && cmd_ready;

   // Advance the raster position, wrapping at row and frame end
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[CW-1:0];
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(WIDTH_RESET);
         height_ff <= HEIGHT_REG_W'(HEIGHT_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

FILE: hdl/grerode_back.sv
// Back end: line store read-modify-write, column minimum and 3x3 window minimum.
`timescale 1ns / 1ps
module grerode_back
   import grerode_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  logic [$clog2(MAX_WIDTH)-1:0]   cmd_index,
   input  logic [PIX_W-1:0]               cmd_pixel,
   input  cmd_flags_type                  cmd_flags,
   input  logic [$clog2(RES_DEPTH+1)-1:0] res_level,
   output logic                           res_valid,
   output rsp_payload_type                res_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int LW    = $clog2(RES_DEPTH + 1);
   localparam int LINE_W = 2 * PIX_W;

   logic                s1_valid_ff;
   logic [CW-1:0]       s1_index_ff;
   logic [PIX_W-1:0]    s1_pixel_ff;
   cmd_flags_type       s1_flags_ff;
   logic                bypass_ff;
   logic [LINE_W-1:0]   bypass_data_ff;
   logic [PIX_W-1:0]    col_left_ff, col_left_in;
   logic [PIX_W-1:0]    col_mid_ff, col_mid_in;
   logic [LINE_W-1:0]   ram_rd, line, wr_line;
   logic [PIX_W-1:0]    up1, up2, col_min;
   logic                pop;

   // Pop only when the result queue is sure to have room for this item
   assign cmd_ready = ((LW + 1)'(res_level) + (LW + 1)'(s1_valid_ff)) < (LW + 1)'(RES_DEPTH);
   assign pop       = cmd_valid && cmd_ready;

   // Both line stores share one RAM word: {two rows above, one row above}
   grerode_ram #(
      .DATA_W (LINE_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_index_ff),
      .wr_data (wr_line),
      .rd_addr (cmd_index),
      .rd_data (ram_rd)
   );

   // Forward a write that lands on the column being read in the same cycle
   always_comb begin
      line    = bypass_ff ? bypass_data_ff : ram_rd;
      up1     = line[PIX_W-1:0];
      up2     = line[LINE_W-1:PIX_W];
      col_min = min3(up2, up1, s1_pixel_ff);
      wr_line = {up1, s1_pixel_ff};
   end

   // Column minimum history of the current row
   always_comb begin
      col_left_in = col_left_ff;
      col_mid_in  = col_mid_ff;
      if (s1_valid_ff) begin
         col_left_in = col_mid_ff;
         col_mid_in  = col_min;
      end
   end

   assign res_valid             = s1_valid_ff && s1_flags_ff.emit;
   assign res_data.eroded_pixel = min3(col_left_ff, col_mid_ff, col_min);
   assign res_data.row_end      = s1_flags_ff.row_end;
   assign res_data.frame_end    = s1_flags_ff.frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         bypass_ff   <= 1'b0;
         col_left_ff <= '0;
         col_mid_ff  <= '0;
      end else begin
         s1_valid_ff <= pop;
         bypass_ff   <= pop && s1_valid_ff && (s1_index_ff == cmd_index);
         col_left_ff <= col_left_in;
         col_mid_ff  <= col_mid_in;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_index_ff <= cmd_index;
         s1_pixel_ff <= cmd_pixel;
         s1_flags_ff <= cmd_flags;
      end
      bypass_data_ff <= wr_line;
   end

endmodule

FILE: hdl/grerode_fifo_inst_note.sv
// Result formatting stage: registers nothing, maps the result queue word onto the output struct.
`timescale 1ns / 1ps
module grerode_rsp_view
   import grerode_pkg::*;
(
   input  logic [$bits(rsp_payload_type)-1:0] word,
   input  logic                               word_valid,
   output rsp_payload_type                    payload
);

   // Results leave with all flags cleared when nothing is shown
   always_comb begin
      payload = rsp_payload_type'(word);
      if (!word_valid) begin
         payload.row_end   = 1'b0;
         payload.frame_end = 1'b0;
      end
   end

endmodule

FILE: hdl/grayscale_erosion_3x3.sv
// Top level of the 3x3 grayscale erosion (minimum) filter.
// Takes one 8-bit pixel per clock in raster order and returns, for every interior pixel, the
// minimum of its 3x3 neighbourhood, one row and one column behind the input; a frame of W x H
// pixels gives (W-2) x (H-2) results, with row_end on the last of each row and frame_end on the
// last of the frame. Sustained rate is one pixel per clock while the output is ready; a pixel's
// result passes through the command queue, the line store RAM's registered read and compare
// stage, and the result queue, and output stalls back up into the input. Both previous rows
// live in one RAM of MAX_WIDTH words, read and rewritten once per pixel, with a forwarding path
// for back-to-back accesses to one column. Registers: index 0 image_width (3..MAX_WIDTH, taken
// from the low 11 bits of the write), index 1 image_height (3..4096); values outside are
// saturated. frame_start restarts the position at row 0, column 0; otherwise the position
// wraps after the last pixel of a frame. Write the registers only while the block is idle.
`timescale 1ns / 1ps
module grayscale_erosion_3x3
   import grerode_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int FL_W  = $bits(cmd_flags_type);
   localparam int CMD_W = CW + PIX_W + FL_W;
   localparam int RSP_W = $bits(rsp_payload_type);
   localparam int LW    = $clog2(RES_DEPTH + 1);

   logic                f_valid, f_ready;
   logic [CW-1:0]       f_index;
   logic [PIX_W-1:0]    f_pixel;
   cmd_flags_type       f_flags;
   logic                b_valid, b_ready;
   logic [CMD_W-1:0]    b_word;
   logic [LW-1:0]       res_level;
   logic                res_valid;
   rsp_payload_type     res_data;
   logic [RSP_W-1:0]    rsp_word;

   // Front: position and classification
   grerode_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd_valid   (f_valid),
      .cmd_ready   (f_ready),
      .cmd_index   (f_index),
      .cmd_pixel   (f_pixel),
      .cmd_flags   (f_flags)
   );

   // Command queue between front and back
   grerode_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_index, f_pixel, f_flags}),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_word),
      .level      ()
   );

   // Back: line stores and minimum filter
   grerode_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (b_valid),
      .cmd_ready (b_ready),
      .cmd_index (b_word[CMD_W-1:PIX_W+FL_W]),
      .cmd_pixel (b_word[PIX_W+FL_W-1:FL_W]),
      .cmd_flags (cmd_flags_type'(b_word[FL_W-1:0])),
      .res_level (res_level),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // Result queue decouples the output handshake
   grerode_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RES_DEPTH)
   ) u_res_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_ready (),
      .push_data  (res_data),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_word),
      .level      (res_level)
   );

   grerode_rsp_view u_rsp_view (
      .word       (rsp_word),
      .word_valid (rsp_valid),
      .payload    (rsp_payload)
   );

endmodule
